FILE: rtl/lr_pkg.sv
// Shared types and codes for the line rasterizer.
// No dependencies; lr_cfg_if, lr_front, lr_queue, lr_back and line_rasterizer import it.
package lr_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  localparam int unsigned REG_INDEX_BITS = 2;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } reg_index_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    op_t  op;
    logic reject;   // start with an endpoint off screen
    logic xneg;     // x decreases
    logic yneg;     // y decreases
    logic ymaj;     // y is the major axis
  } cmd_ctrl_t;

endpackage

FILE: rtl/lr_in_if.sv
// Command channel of the line rasterizer: valid/ready plus command fields.
// Depends on nothing.
interface lr_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: rtl/lr_out_if.sv
// Pixel result channel of the line rasterizer: valid/ready plus result fields.
// Depends on nothing.
interface lr_out_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;
  logic [1:0]            status;

  modport source (output valid, pixel_x, pixel_y, last_pixel, status, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, status, output ready);
endinterface

FILE: rtl/lr_cfg_if.sv
// Register write channel of the line rasterizer: valid/ready, index, data.
// Depends on lr_pkg for the index width.
interface lr_cfg_if #(
  parameter int unsigned COORD_BITS = 12
);
  import lr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [REG_INDEX_BITS-1:0] index;
  logic [COORD_BITS:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/lr_front.sv
// Front end: screen registers, range check and octant classification.
// Depends on lr_pkg, lr_in_if, lr_cfg_if; feeds lr_queue.
module lr_front import lr_pkg::*; #(
  parameter int unsigned COORD_BITS   = 12,
  parameter int unsigned RESET_WIDTH  = 800,
  parameter int unsigned RESET_HEIGHT = 600
) (
  input  logic                    clk,
  input  logic                    rst,
  lr_in_if.sink                   cmd,
  lr_cfg_if.sink                  cfg,
  input  logic                    full,
  output logic                    push,
  output cmd_ctrl_t               ctrl,
  output logic [5*COORD_BITS-1:0] data
);

  localparam int unsigned CB = COORD_BITS;

  logic [CB:0]   screen_width;
  logic [CB:0]   screen_height;
  logic [CB-1:0] dx;
  logic [CB-1:0] dy;
  logic          xneg;
  logic          yneg;
  logic          ymaj;
  logic          off_screen;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= (CB+1)'(RESET_WIDTH);
      screen_height <= (CB+1)'(RESET_HEIGHT);
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
        REG_SCREEN_HEIGHT: screen_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  always_comb begin
    off_screen = ({1'b0, cmd.start_x} >= screen_width) || ({1'b0, cmd.end_x} >= screen_width) ||
                 ({1'b0, cmd.start_y} >= screen_height) || ({1'b0, cmd.end_y} >= screen_height);
    xneg = cmd.end_x < cmd.start_x;
    yneg = cmd.end_y < cmd.start_y;
    dx   = xneg ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
    dy   = yneg ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
    ymaj = dx < dy;

    ctrl.op     = op_t'(cmd.operation);
    ctrl.reject = off_screen;
    ctrl.xneg   = xneg;
    ctrl.yneg   = yneg;
    ctrl.ymaj   = ymaj;
    // {target, minor, major, start_y, start_x}
    data = {ymaj ? cmd.end_y : cmd.end_x,
            ymaj ? dx : dy,
            ymaj ? dy : dx,
            cmd.start_y,
            cmd.start_x};
  end

endmodule

FILE: rtl/lr_queue.sv
// Two-entry command queue between front and back ends.
// Depends on lr_pkg for the control struct.
module lr_queue import lr_pkg::*; #(
  parameter int unsigned DATA_BITS = 60
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cmd_ctrl_t            push_ctrl,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output cmd_ctrl_t            head_ctrl,
  output logic [DATA_BITS-1:0] head_data
);

  cmd_ctrl_t            ctrl_mem [2];
  logic [DATA_BITS-1:0] data_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head_ctrl = ctrl_mem[rd_ptr];
  assign head_data = data_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr] <= push_ctrl;
      data_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/lr_back.sv
// Back end: Bresenham line state, one result beat per fired command, output register.
// Depends on lr_pkg and lr_out_if; reads commands from lr_queue.
module lr_back import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  cmd_ctrl_t               ctrl,
  input  logic [5*COORD_BITS-1:0] data,
  output logic                    pop,
  lr_out_if.source                pix
);

  localparam int unsigned CB = COORD_BITS;

  logic [CB-1:0] current_x;
  logic [CB-1:0] current_y;
  logic [CB-1:0] target_major;
  logic [CB-1:0] major_delta;
  logic [CB-1:0] minor_delta;
  logic [CB:0]   error_term;
  logic          xneg;
  logic          yneg;
  logic          ymaj;
  logic          line_active;

  logic [CB-1:0] in_sx;
  logic [CB-1:0] in_sy;
  logic [CB-1:0] in_major;
  logic [CB-1:0] in_minor;
  logic [CB-1:0] in_target;

  logic [CB:0]   err_sum;
  logic          minor_moves;
  logic [CB:0]   error_next;
  logic [CB-1:0] x_step;
  logic [CB-1:0] y_step;
  logic [CB-1:0] x_next;
  logic [CB-1:0] y_next;
  logic          at_end;

  assign {in_target, in_minor, in_major, in_sy, in_sx} = data;

  // fire when a command waits and the output register is free or draining
  assign pop = cmd_valid && (!pix.valid || pix.ready);

  always_comb begin
    err_sum     = error_term + {1'b0, minor_delta};
    minor_moves = err_sum >= {1'b0, major_delta};
    error_next  = minor_moves ? err_sum - {1'b0, major_delta} : err_sum;
    x_step      = xneg ? current_x - 1'b1 : current_x + 1'b1;
    y_step      = yneg ? current_y - 1'b1 : current_y + 1'b1;
    if (ymaj) begin
      y_next = y_step;
      x_next = minor_moves ? x_step : current_x;
      at_end = y_step == target_major;
    end else begin
      x_next = x_step;
      y_next = minor_moves ? y_step : current_y;
      at_end = x_step == target_major;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_x    <= '0;
      current_y    <= '0;
      target_major <= '0;
      major_delta  <= '0;
      minor_delta  <= '0;
      error_term   <= '0;
      xneg         <= 1'b0;
      yneg         <= 1'b0;
      ymaj         <= 1'b0;
      line_active  <= 1'b0;
      pix.valid    <= 1'b0;
    end else begin
      // a new beat loads, otherwise an untaken beat holds
      pix.valid <= pop || (pix.valid && !pix.ready);
      if (pop) begin
        case (ctrl.op)
          OP_START: begin
            if (ctrl.reject) begin
              line_active    <= 1'b0;
              pix.pixel_x    <= '0;
              pix.pixel_y    <= '0;
              pix.last_pixel <= 1'b0;
              pix.status     <= ST_REJECT;
            end else begin
              current_x      <= in_sx;
              current_y      <= in_sy;
              target_major   <= in_target;
              major_delta    <= in_major;
              minor_delta    <= in_minor;
              error_term     <= {2'b00, in_major[CB-1:1]};
              xneg           <= ctrl.xneg;
              yneg           <= ctrl.yneg;
              ymaj           <= ctrl.ymaj;
              line_active    <= in_major != '0;
              pix.pixel_x    <= in_sx;
              pix.pixel_y    <= in_sy;
              pix.last_pixel <= in_major == '0;
              pix.status     <= ST_PIXEL;
            end
          end
          OP_STEP: begin
            if (!line_active) begin
              pix.pixel_x    <= '0;
              pix.pixel_y    <= '0;
              pix.last_pixel <= 1'b0;
              pix.status     <= ST_IDLE;
            end else begin
              error_term     <= error_next;
              current_x      <= x_next;
              current_y      <= y_next;
              line_active    <= !at_end;
              pix.pixel_x    <= x_next;
              pix.pixel_y    <= y_next;
              pix.last_pixel <= at_end;
              pix.status     <= ST_PIXEL;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: front end, command queue, back end.
// Depends on lr_pkg, the three channel interfaces, lr_front, lr_queue, lr_back.
//
// A start beat (operation 0) carries both endpoints; if any coordinate is at or
// beyond the screen size it is rejected (status 2) and any line in progress is
// dropped, otherwise the start pixel comes back (last_pixel set for a one-point
// line). Each step beat (operation 1) returns the next pixel along the line, with
// last_pixel on the end point; a step with no line in progress returns status 1.
// Every command beat gives exactly one result beat, in order. Throughput is one
// beat per clock while the result channel takes every beat: the front end checks
// range and picks the octant in the accept cycle and writes the classified
// command into a two-entry queue; the back end does one error-term add, compare
// and coordinate increment per clock and loads the result register, so a result
// passes through the queue and then the result register before it is presented.
// The queue and the result register decouple the two sides, so a stall on the
// result channel does not stop the command channel until the queue fills.
// Screen size registers (index 0 width, index 1 height) may be written only while
// no command is in flight; cfg.ready is always high. Reset size is 800 x 600.
module line_rasterizer import lr_pkg::*; #(
  parameter int unsigned COORD_BITS   = 12,
  parameter int unsigned RESET_WIDTH  = 800,
  parameter int unsigned RESET_HEIGHT = 600
) (
  input  logic     clk,
  input  logic     rst,
  lr_in_if.sink    cmd,
  lr_cfg_if.sink   cfg,
  lr_out_if.source pix
);

  localparam int unsigned DATA_BITS = 5 * COORD_BITS;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_valid;
  cmd_ctrl_t            push_ctrl;
  cmd_ctrl_t            head_ctrl;
  logic [DATA_BITS-1:0] push_data;
  logic [DATA_BITS-1:0] head_data;

  lr_front #(
    .COORD_BITS  (COORD_BITS),
    .RESET_WIDTH (RESET_WIDTH),
    .RESET_HEIGHT(RESET_HEIGHT)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .cfg (cfg),
    .full(q_full),
    .push(q_push),
    .ctrl(push_ctrl),
    .data(push_data)
  );

  lr_queue #(
    .DATA_BITS(DATA_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ctrl(push_ctrl),
    .push_data(push_data),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head_ctrl(head_ctrl),
    .head_data(head_data)
  );

  lr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .ctrl     (head_ctrl),
    .data     (head_data),
    .pop      (q_pop),
    .pix      (pix)
  );

  // non-pixel results carry a zero payload
  assert property (@(posedge clk) disable iff (rst)
    pix.valid && (pix.status != ST_PIXEL) |-> (pix.pixel_x == '0) && (pix.pixel_y == '0) &&
    !pix.last_pixel)
    else $error("non-pixel result with nonzero payload");

  // a new result only ever comes from a queued command
  assert property (@(posedge clk) disable iff (rst)
    !pix.valid |=> !pix.valid || $past(q_valid))
    else $error("result produced with empty queue");

  // a full queue always presents a command to the back end
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> q_valid)
    else $error("queue full but empty");

endmodule
